// ===== rtl/core/e2u_pkg.sv =====
// ----------------------------------------------------------------------------
// e2u_pkg
// Types, constants and elaboration-time tables for the epoch seconds to
// UTC date and time converter.
// ----------------------------------------------------------------------------
package e2u_pkg;

    localparam int unsigned FIRST_YEAR   = 1970;
    localparam int unsigned YEAR_COUNT   = 69;
    localparam int unsigned YEAR_IDX_W   = $clog2(YEAR_COUNT);
    localparam int unsigned MONTH_COUNT  = 12;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    // Exact reciprocals: (x >> 7) / 675 for 24-bit x, x / 3600 for x below
    // 86400, x / 60 for x below 3600.
    localparam logic [24:0] DAY_RECIP  = 25'd25451659;
    localparam int unsigned DAY_SHIFT  = 34;
    localparam logic [17:0] HOUR_RECIP = 18'd149131;
    localparam int unsigned HOUR_SHIFT = 29;
    localparam logic [11:0] MIN_RECIP  = 12'd2185;
    localparam int unsigned MIN_SHIFT  = 17;

    typedef logic [YEAR_COUNT-1:0][14:0]  t_year_start_tab;
    typedef logic [YEAR_COUNT-1:0]        t_leap_mask;
    typedef logic [MONTH_COUNT-1:0][8:0]  t_month_start_tab;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
    } t_tod_en;

    function automatic logic f_is_leap(input int unsigned y);
        return ((y % 400) == 0) || (((y % 4) == 0) && ((y % 100) != 0));
    endfunction

    function automatic t_year_start_tab f_year_starts();
        t_year_start_tab tab;
        int unsigned     acc;
        acc = 0;
        for (int unsigned i = 0; i < YEAR_COUNT; i++) begin
            tab[i] = 15'(acc);
            acc = acc + (f_is_leap(FIRST_YEAR + i) ? 366 : 365);
        end
        return tab;
    endfunction

    function automatic t_leap_mask f_leap_mask();
        t_leap_mask m;
        for (int unsigned i = 0; i < YEAR_COUNT; i++) begin
            m[i] = f_is_leap(FIRST_YEAR + i);
        end
        return m;
    endfunction

    function automatic int unsigned f_month_len(input int unsigned m);
        int unsigned len;
        unique case (m)
            1:       len = 28;
            3, 5, 8, 10: len = 30;
            default: len = 31;
        endcase
        return len;
    endfunction

    // Start of each month within a common year, counted from 0.
    function automatic t_month_start_tab f_month_starts();
        t_month_start_tab tab;
        int unsigned      acc;
        acc = 0;
        for (int unsigned m = 0; m < MONTH_COUNT; m++) begin
            tab[m] = 9'(acc);
            acc = acc + f_month_len(m);
        end
        return tab;
    endfunction

    localparam t_year_start_tab  YEAR_START  = f_year_starts();
    localparam t_leap_mask       LEAP_MASK   = f_leap_mask();
    localparam t_month_start_tab MONTH_START = f_month_starts();

endpackage

// ===== rtl/core/e2u_tod_split.sv =====
// ----------------------------------------------------------------------------
// e2u_tod_split
// Four-stage split of the second of the day into hour, minute and second,
// using reciprocal multiplies with a register after each product.
// ----------------------------------------------------------------------------
module e2u_tod_split (
    input  logic              i_clk,
    input  e2u_pkg::t_tod_en  i_en,
    input  logic [16:0]       i_tod,
    output logic [4:0]        o_hour,
    output logic [5:0]        o_minute,
    output logic [5:0]        o_second
);

    logic [33:0] r_hprod;
    logic [16:0] r_tod_a;
    logic [4:0]  r_hour_b, r_hour_c, r_hour_d;
    logic [11:0] r_rem_b, r_rem_c;
    logic [23:0] r_mprod;
    logic [5:0]  r_min_d, r_sec_d;

    logic [4:0]  n_hour;
    logic [16:0] w_hour_secs;
    logic [11:0] n_rem;
    logic [5:0]  n_min;
    logic [11:0] w_min_secs;
    logic [5:0]  n_sec;

    always_comb begin
        n_hour      = r_hprod[e2u_pkg::HOUR_SHIFT+4:e2u_pkg::HOUR_SHIFT];
        w_hour_secs = 17'(n_hour) * e2u_pkg::SECS_PER_HOUR;
        n_rem       = 12'(r_tod_a - w_hour_secs);
        n_min       = r_mprod[e2u_pkg::MIN_SHIFT+5:e2u_pkg::MIN_SHIFT];
        w_min_secs  = 12'(n_min) * e2u_pkg::SECS_PER_MIN;
        n_sec       = 6'(r_rem_c - w_min_secs);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_hprod <= 34'(i_tod) * 34'(e2u_pkg::HOUR_RECIP);
            r_tod_a <= i_tod;
        end
        if (i_en.b) begin
            r_hour_b <= n_hour;
            r_rem_b  <= n_rem;
        end
        if (i_en.c) begin
            r_mprod  <= 24'(r_rem_b) * 24'(e2u_pkg::MIN_RECIP);
            r_rem_c  <= r_rem_b;
            r_hour_c <= r_hour_b;
        end
        if (i_en.d) begin
            r_hour_d <= r_hour_c;
            r_min_d  <= n_min;
            r_sec_d  <= n_sec;
        end
    end

    assign o_hour   = r_hour_d;
    assign o_minute = r_min_d;
    assign o_second = r_sec_d;

endmodule

// ===== rtl/core/epoch_seconds_to_utc_datetime_core.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_datetime_core
// Converts seconds since 1970-01-01T00:00:00Z into days since the epoch,
// the Gregorian date and the UTC time of day.
//
//   Channel   Direction  Handshake            Word
//   input     in         i_valid / o_stall    i_epoch_seconds
//   output    out        o_valid / i_stall    days, date and time of day
//
// Six register stages; a word enters every cycle while o_stall is low.
// Depth is set by the day divide multiply, the year and month compare
// banks and the hour and minute multiplies. Reset clears only the stage
// valid bits. A stall at the output holds each full stage with only full
// stages after it; other stages keep moving, so no word is lost.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_datetime_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [30:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_days_since_epoch,
    output logic [10:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    localparam int unsigned STAGES = 6;
    localparam int unsigned YW     = e2u_pkg::YEAR_IDX_W;
    localparam int unsigned MC     = e2u_pkg::MONTH_COUNT;

    logic [STAGES:1] r_valid, n_valid, w_en, w_prev;

    // Stage registers.
    logic [30:0]   r1_secs;
    logic [48:0]   r1_prod;
    logic [14:0]   r2_days, r3_days, r4_days, r5_days, r6_days;
    logic [16:0]   r2_tod;
    logic [YW-1:0] r3_yidx;
    logic [8:0]    r4_doy, r5_doy;
    logic          r4_leap, r5_leap;
    logic [10:0]   r4_year, r5_year, r6_year;
    logic [3:0]    r5_month, r6_month;
    logic [4:0]    r6_dom;

    logic [14:0]                 n2_days;
    logic [31:0]                 w_day_secs;
    logic [16:0]                 n2_tod;
    logic [e2u_pkg::YEAR_COUNT-1:1] w_ycmp;
    logic [YW-1:0]               n3_yidx;
    logic [8:0]                  n4_doy;
    logic [MC-1:1]               w_mcmp;
    logic [3:0]                  n5_month;
    logic [8:0]                  w_mbase;
    logic [4:0]                  n6_dom;
    e2u_pkg::t_tod_en            w_tod_en;

    // Handshake: a stage loads when it is empty or the next stage loads.
    always_comb begin
        w_en[STAGES] = !r_valid[STAGES] || !i_stall;
        for (int k = STAGES - 1; k >= 1; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
        w_prev  = {r_valid[STAGES-1:1], i_valid};
        n_valid = (w_en & w_prev) | (~w_en & r_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !w_en[1];
    assign o_valid = r_valid[STAGES];

    always_comb begin
        n2_days    = r1_prod[e2u_pkg::DAY_SHIFT+14:e2u_pkg::DAY_SHIFT];
        w_day_secs = 32'(n2_days) * 32'(e2u_pkg::SECS_PER_DAY);
        n2_tod     = 17'({1'b0, r1_secs} - w_day_secs);

        // Years completed: how many year boundaries lie at or below the day.
        for (int i = 1; i < e2u_pkg::YEAR_COUNT; i++) begin
            w_ycmp[i] = r2_days >= e2u_pkg::YEAR_START[i];
        end
        n3_yidx = YW'($countones(w_ycmp));

        n4_doy = 9'(r3_days - e2u_pkg::YEAR_START[r3_yidx]);

        // In a leap year every month after February starts one day later.
        for (int k = 1; k < MC; k++) begin
            w_mcmp[k] = r4_doy >= (e2u_pkg::MONTH_START[k] + 9'(r4_leap && (k >= 2)));
        end
        n5_month = 4'(1 + $countones(w_mcmp));

        w_mbase = e2u_pkg::MONTH_START[r5_month - 4'd1]
                + 9'(r5_leap && (r5_month >= 4'd3));
        n6_dom  = 5'(r5_doy - w_mbase + 9'd1);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_secs <= i_epoch_seconds;
            r1_prod <= 49'(i_epoch_seconds[30:7]) * 49'(e2u_pkg::DAY_RECIP);
        end
        if (w_en[2]) begin
            r2_days <= n2_days;
            r2_tod  <= n2_tod;
        end
        if (w_en[3]) begin
            r3_days <= r2_days;
            r3_yidx <= n3_yidx;
        end
        if (w_en[4]) begin
            r4_days <= r3_days;
            r4_doy  <= n4_doy;
            r4_leap <= e2u_pkg::LEAP_MASK[r3_yidx];
            r4_year <= 11'(e2u_pkg::FIRST_YEAR) + 11'(r3_yidx);
        end
        if (w_en[5]) begin
            r5_days  <= r4_days;
            r5_doy   <= r4_doy;
            r5_leap  <= r4_leap;
            r5_year  <= r4_year;
            r5_month <= n5_month;
        end
        if (w_en[6]) begin
            r6_days  <= r5_days;
            r6_year  <= r5_year;
            r6_month <= r5_month;
            r6_dom   <= n6_dom;
        end
    end

    assign w_tod_en.a = w_en[3];
    assign w_tod_en.b = w_en[4];
    assign w_tod_en.c = w_en[5];
    assign w_tod_en.d = w_en[6];

    e2u_tod_split u_tod_split (
        .i_clk    (i_clk),
        .i_en     (w_tod_en),
        .i_tod    (r2_tod),
        .o_hour   (o_hour),
        .o_minute (o_minute),
        .o_second (o_second)
    );

    assign o_days_since_epoch = r6_days;
    assign o_year             = r6_year;
    assign o_month            = r6_month;
    assign o_day_of_month     = r6_dom;

endmodule
